>>> hdl/lge_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_pkg: shared types and constants of the life grid engine
// Action codes, controller states and the command/status bundles between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package lge_pkg;

    localparam int ACTION_W = 2;
    localparam int ROW_W    = 4;
    localparam int COL_W    = 4;

    // B3/S23
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE   = 2'd0,
        ACT_ADVANCE = 2'd1,
        ACT_READ    = 2'd2,
        ACT_NONE    = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_ACCESS,
        S_ADVANCE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;     // latch the input word, reset sweep window
        logic rd_issue;    // read the addressed row
        logic acc_finish;  // finish a single-cell access
        logic adv_step;    // one row step of the generation sweep
        logic load_out;    // move the result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic    on_grid;  // latched address lies in the grid
        logic    adv_last; // current sweep step is the final one
        logic    out_free; // output register can take a word this cycle
    } t_dp_sts;

endpackage

>>> hdl/lge_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_if: valid/ready channels of the life grid engine
// Command channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface lge_in_if;
    logic                         valid;
    logic                         ready;
    logic [lge_pkg::ACTION_W-1:0] action;
    logic [lge_pkg::ROW_W-1:0]    row;
    logic [lge_pkg::COL_W-1:0]    col;
    logic                         write_value;

    modport source (output valid, action, row, col, write_value, input ready);
    modport sink   (input valid, action, row, col, write_value, output ready);
endinterface

interface lge_out_if;
    logic                         valid;
    logic                         ready;
    logic                         cell_state;
    logic [lge_pkg::ACTION_W-1:0] action_done;

    modport source (output valid, cell_state, action_done, input ready);
    modport sink   (input valid, cell_state, action_done, output ready);
endinterface

>>> hdl/lge_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lge_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/lge_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_ctrl: sequencing FSM of the life grid engine
// Accepts one command word at a time and steps the datapath through it.
// ----------------------------------------------------------------------------
module lge_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic [lge_pkg::ACTION_W-1:0] i_in_action,
    output logic                         o_in_ready,
    input  lge_pkg::t_dp_sts             i_sts,
    output lge_pkg::t_dp_cmd             o_cmd
);

    lge_pkg::t_state r_state;
    lge_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lge_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lge_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_action == lge_pkg::ACT_ADVANCE) begin
                        n_state = lge_pkg::S_ADVANCE;
                    end else if (i_in_action == lge_pkg::ACT_WRITE ||
                                 i_in_action == lge_pkg::ACT_READ) begin
                        n_state = lge_pkg::S_READ;
                    end else begin
                        n_state = lge_pkg::S_DONE;
                    end
                end
            end
            lge_pkg::S_READ: begin
                n_state = i_sts.on_grid ? lge_pkg::S_ACCESS : lge_pkg::S_DONE;
            end
            lge_pkg::S_ACCESS: begin
                n_state = lge_pkg::S_DONE;
            end
            lge_pkg::S_ADVANCE: begin
                if (i_sts.adv_last) begin
                    n_state = lge_pkg::S_DONE;
                end
            end
            lge_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = lge_pkg::S_IDLE;
                end
            end
            default: n_state = lge_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            lge_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            lge_pkg::S_READ: begin
                o_cmd.rd_issue = i_sts.on_grid;
            end
            lge_pkg::S_ACCESS: begin
                o_cmd.acc_finish = 1'b1;
            end
            lge_pkg::S_ADVANCE: begin
                o_cmd.adv_step = 1'b1;
            end
            lge_pkg::S_DONE: begin
                o_cmd.load_out = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> hdl/lge_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_dpath: grid storage and generation datapath
// Row RAM with per-row valid bits, three-row sweep window, result and
// output registers.
// ----------------------------------------------------------------------------
module lge_dpath #(
    parameter int GRID_SIZE = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lge_pkg::t_dp_cmd             i_cmd,
    output lge_pkg::t_dp_sts             o_sts,
    input  logic [lge_pkg::ACTION_W-1:0] i_in_action,
    input  logic [lge_pkg::ROW_W-1:0]    i_in_row,
    input  logic [lge_pkg::COL_W-1:0]    i_in_col,
    input  logic                         i_in_write_value,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_out_cell_state,
    output logic [lge_pkg::ACTION_W-1:0] o_out_action_done
);

    localparam int AW    = $clog2(GRID_SIZE);
    localparam int CW    = $clog2(GRID_SIZE);
    localparam int CNT_W = $clog2(GRID_SIZE + 2);

    // latched command word
    lge_pkg::t_action            r_action;
    logic [lge_pkg::ROW_W-1:0]   r_row;
    logic [lge_pkg::COL_W-1:0]   r_col;
    logic                        r_wv;

    logic [GRID_SIZE-1:0] r_valid;
    logic [GRID_SIZE-1:0] r_prev;
    logic [GRID_SIZE-1:0] r_cur;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_rd_ok;
    logic                 r_cell;

    logic                  r_out_valid;
    logic                  r_out_cell;
    lge_pkg::t_action      r_out_action;

    logic                 on_grid;
    logic [AW-1:0]        row_addr;
    logic [CW-1:0]        col_idx;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [GRID_SIZE-1:0] ram_q;
    logic [GRID_SIZE-1:0] rd_row;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [GRID_SIZE-1:0] wr_data;
    logic [GRID_SIZE-1:0] mod_row;
    logic [GRID_SIZE-1:0] life_row;
    logic [CNT_W-1:0]     wr_cnt;
    logic                 sweep_rd;
    logic                 sweep_wr;

    assign on_grid  = (32'(r_row) < 32'(GRID_SIZE)) && (32'(r_col) < 32'(GRID_SIZE));
    assign row_addr = AW'(r_row);
    assign col_idx  = CW'(r_col);

    assign sweep_rd = i_cmd.adv_step && (r_cnt < CNT_W'(GRID_SIZE));
    assign sweep_wr = i_cmd.adv_step && (r_cnt >= CNT_W'(2));
    assign wr_cnt   = r_cnt - CNT_W'(2);

    assign rd_en   = i_cmd.rd_issue || sweep_rd;
    assign rd_addr = i_cmd.adv_step ? r_cnt[AW-1:0] : row_addr;

    // rows never written since reset read as dead
    assign rd_row = r_rd_ok ? ram_q : '0;

    always_comb begin
        mod_row          = rd_row;
        mod_row[col_idx] = r_wv;
    end

    // B3/S23 on the row held in r_cur, neighbors from r_prev and rd_row
    logic [GRID_SIZE+1:0] pad_prev;
    logic [GRID_SIZE+1:0] pad_cur;
    logic [GRID_SIZE+1:0] pad_next;

    assign pad_prev = {1'b0, r_prev, 1'b0};
    assign pad_cur  = {1'b0, r_cur,  1'b0};
    assign pad_next = {1'b0, rd_row, 1'b0};

    for (genvar c = 0; c < GRID_SIZE; c++) begin : g_col
        logic [3:0] nb;
        assign nb = 4'(pad_prev[c]) + 4'(pad_prev[c+1]) + 4'(pad_prev[c+2])
                  + 4'(pad_cur[c])                      + 4'(pad_cur[c+2])
                  + 4'(pad_next[c]) + 4'(pad_next[c+1]) + 4'(pad_next[c+2]);
        assign life_row[c] = (nb == 4'(lge_pkg::BIRTH_COUNT)) ||
                             (r_cur[c] && (nb == 4'(lge_pkg::SURVIVE_COUNT)));
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = row_addr;
        wr_data = mod_row;
        if (sweep_wr) begin
            wr_en   = 1'b1;
            wr_addr = wr_cnt[AW-1:0];
            wr_data = life_row;
        end else if (i_cmd.acc_finish && (r_action == lge_pkg::ACT_WRITE)) begin
            wr_en = 1'b1;
        end
    end

    lge_ram #(
        .WIDTH (GRID_SIZE),
        .DEPTH (GRID_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_rd_ok     <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            r_rd_ok <= rd_en && r_valid[rd_addr];
            if (i_cmd.capture) begin
                r_cnt <= '0;
            end else if (i_cmd.adv_step) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= lge_pkg::t_action'(i_in_action);
            r_row    <= i_in_row;
            r_col    <= i_in_col;
            r_wv     <= i_in_write_value;
            r_cell   <= 1'b0;
            r_prev   <= '0;
            r_cur    <= '0;
        end else begin
            if (i_cmd.acc_finish) begin
                r_cell <= (r_action == lge_pkg::ACT_WRITE) ? r_wv : rd_row[col_idx];
            end
            if (i_cmd.adv_step) begin
                r_prev <= r_cur;
                r_cur  <= rd_row;
            end
        end
        if (i_cmd.load_out) begin
            r_out_cell   <= r_cell;
            r_out_action <= r_action;
        end
    end

    assign o_sts.on_grid  = on_grid;
    assign o_sts.adv_last = (r_cnt == CNT_W'(GRID_SIZE + 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid       = r_out_valid;
    assign o_out_cell_state  = r_out_cell;
    assign o_out_action_done = r_out_action;

endmodule

>>> hdl/life_grid_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// life_grid_engine_top: Conway B3/S23 grid engine
// Square grid of one-bit cells with single-cell write/read and a one
// generation advance, dead cells beyond the border.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one command word: action (0 write, 1 advance, 2 read),
//   row, col and write_value. o_out returns exactly one word per command:
//   cell_state (the addressed cell after the action, 0 for advance or an
//   address off the grid) and action_done (echo of the action code).
//   Commands are handled one at a time; i_in.ready is high only while the
//   engine is idle.
//   The next command can be taken in the cycle after the result is loaded.
//   An advance is a row sweep through a three-row window: one RAM row read
//   and one new row written per cycle, plus two steps to fill and drain the
//   window and one to load the output register.
//   Results sit in an output register; a new command is accepted while a
//   result waits. When the receiver stalls and a second result is ready,
//   the engine holds it and does not accept further commands.
//   Reset (synchronous, active low) clears the row valid bits, so the whole
//   grid reads as dead at once with no clearing pass; the RAM itself is not
//   touched. The output register comes out of reset empty.
// ----------------------------------------------------------------------------
module life_grid_engine_top #(
    parameter int GRID_SIZE = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lge_in_if.sink    i_in,
    lge_out_if.source o_out
);

    lge_pkg::t_dp_cmd cmd;
    lge_pkg::t_dp_sts sts;

    // sequencing
    lge_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .o_in_ready  (i_in.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // grid storage, generation logic and output register
    lge_dpath #(
        .GRID_SIZE (GRID_SIZE)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_in_action       (i_in.action),
        .i_in_row          (i_in.row),
        .i_in_col          (i_in.col),
        .i_in_write_value  (i_in.write_value),
        .o_out_valid       (o_out.valid),
        .i_out_ready       (o_out.ready),
        .o_out_cell_state  (o_out.cell_state),
        .o_out_action_done (o_out.action_done)
    );

endmodule

>>> hdl/lge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lge_checker: port-level checks of the life grid engine
// Watches the top-level channels; attached by bind.
// ----------------------------------------------------------------------------
module lge_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic                         i_out_cell_state,
    input logic [lge_pkg::ACTION_W-1:0] i_out_action_done
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_cell_state)
                                        && $stable(i_out_action_done))
        else $error("result word changed while stalled");

    // one command in flight: no accept on the cycle after an accept
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("command accepted while another is in flight");

    // advance reports no cell
    a_adv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_action_done == lge_pkg::ACT_ADVANCE) |-> !i_out_cell_state)
        else $error("advance result carries a live cell");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid after reset");

endmodule

bind life_grid_engine_top lge_checker u_lge_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in.valid),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_out_cell_state  (o_out.cell_state),
    .i_out_action_done (o_out.action_done)
);
